[hdl/pdcrc_pkg.sv]
// ----------------------------------------------------------------------------
// pdcrc_pkg
// Shared types, constants and the CRC-16/CCITT byte update for the deframer.
// ----------------------------------------------------------------------------
package pdcrc_pkg;

    // APB register map: register i at byte address 4*i
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] REG_SYNC_THIRD  = 3'd2;
    localparam logic [2:0] REG_MAX_PAYLOAD = 3'd3;
    localparam logic [2:0] REG_MAX_BUFFER  = 3'd4;
    localparam logic [2:0] REG_CRC_SEED    = 3'd5;

    localparam logic [7:0]  RST_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'h55;
    localparam logic [7:0]  RST_SYNC_THIRD  = 8'hA5;
    localparam logic [15:0] RST_MAX_PAYLOAD = 16'd1024;
    localparam logic [15:0] RST_MAX_BUFFER  = 16'd1035;
    localparam logic [15:0] RST_CRC_SEED    = 16'hFFFF;

    // result kinds
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_SHORT    = 3'd2;
    localparam logic [2:0] ST_BAD_SYNC = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;

    // frame layout
    localparam logic [15:0] POS_SYNC_FIRST  = 16'd0;
    localparam logic [15:0] POS_SYNC_SECOND = 16'd1;
    localparam logic [15:0] POS_SYNC_THIRD  = 16'd2;
    localparam logic [15:0] POS_SEQ_LO      = 16'd3;
    localparam logic [15:0] POS_SEQ_HI      = 16'd4;
    localparam logic [15:0] POS_VERSION     = 16'd5;
    localparam logic [15:0] POS_COMMAND     = 16'd6;
    localparam logic [15:0] POS_LEN_LO      = 16'd7;
    localparam logic [15:0] POS_LEN_HI      = 16'd8;
    localparam logic [15:0] HDR_LEN         = 16'd9;
    localparam logic [16:0] MIN_FRAME       = 17'd11;
    localparam logic [15:0] POS_MAX         = 16'hFFFF;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  sync_third;
        logic [15:0] max_payload_len;
        logic [15:0] max_buffer_len;
        logic [15:0] crc_seed;
    } t_cfg;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  payload_data;
        logic [15:0] payload_offset;
        logic [2:0]  status_code;
        logic [15:0] sequence_id;
        logic [7:0]  protocol_version;
        logic [7:0]  command_code;
        logic [15:0] payload_length;
        logic [15:0] received_check;
        logic [15:0] computed_check;
    } t_result;

    // MSB-first CRC-16/CCITT, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[hdl/pdcrc_if.sv]
// ----------------------------------------------------------------------------
// pdcrc_if
// Valid/ready channels: received bytes in, payload bytes and status out.
// ----------------------------------------------------------------------------
interface pdcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface pdcrc_out_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  payload_data;
    logic [15:0] payload_offset;
    logic [2:0]  status_code;
    logic [15:0] sequence_id;
    logic [7:0]  protocol_version;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
    logic [15:0] received_check;
    logic [15:0] computed_check;

    modport source (
        output valid, output item_kind, output payload_data, output payload_offset,
        output status_code, output sequence_id, output protocol_version,
        output command_code, output payload_length, output received_check,
        output computed_check, input ready
    );
    modport sink (
        input valid, input item_kind, input payload_data, input payload_offset,
        input status_code, input sequence_id, input protocol_version,
        input command_code, input payload_length, input received_check,
        input computed_check, output ready
    );
endinterface

[hdl/pdcrc_regs.sv]
// ----------------------------------------------------------------------------
// pdcrc_regs
// APB configuration registers of the deframer.
// ----------------------------------------------------------------------------
module pdcrc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdcrc_pkg::APB_AW-1:0] paddr,
    input  logic [pdcrc_pkg::APB_DW-1:0] pwdata,
    output logic [pdcrc_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output pdcrc_pkg::t_cfg             o_cfg
);
    import pdcrc_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first      <= RST_SYNC_FIRST;
            r_cfg.sync_second     <= RST_SYNC_SECOND;
            r_cfg.sync_third      <= RST_SYNC_THIRD;
            r_cfg.max_payload_len <= RST_MAX_PAYLOAD;
            r_cfg.max_buffer_len  <= RST_MAX_BUFFER;
            r_cfg.crc_seed        <= RST_CRC_SEED;
        end else if (wr_en) begin
            unique case (idx)
                REG_SYNC_FIRST:  r_cfg.sync_first      <= pwdata[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second     <= pwdata[7:0];
                REG_SYNC_THIRD:  r_cfg.sync_third      <= pwdata[7:0];
                REG_MAX_PAYLOAD: r_cfg.max_payload_len <= pwdata[15:0];
                REG_MAX_BUFFER:  r_cfg.max_buffer_len  <= pwdata[15:0];
                REG_CRC_SEED:    r_cfg.crc_seed        <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SYNC_FIRST:  prdata = {24'd0, r_cfg.sync_first};
            REG_SYNC_SECOND: prdata = {24'd0, r_cfg.sync_second};
            REG_SYNC_THIRD:  prdata = {24'd0, r_cfg.sync_third};
            REG_MAX_PAYLOAD: prdata = {16'd0, r_cfg.max_payload_len};
            REG_MAX_BUFFER:  prdata = {16'd0, r_cfg.max_buffer_len};
            REG_CRC_SEED:    prdata = {16'd0, r_cfg.crc_seed};
            default:         prdata = '0;
        endcase
    end

endmodule

[hdl/pdcrc_parse.sv]
// ----------------------------------------------------------------------------
// pdcrc_parse
// Per-buffer frame state, header capture, running CRC and status decision.
// ----------------------------------------------------------------------------
module pdcrc_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdcrc_pkg::t_cfg    i_cfg,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output logic               o_has_result,
    output pdcrc_pkg::t_result o_result
);
    import pdcrc_pkg::*;

    logic [15:0] r_pos,  n_pos;
    logic        r_sync, n_sync;
    logic [15:0] r_seq,  n_seq;
    logic [7:0]  r_ver,  n_ver;
    logic [7:0]  r_cmd,  n_cmd;
    logic [15:0] r_len,  n_len;
    logic [15:0] r_crc,  n_crc;
    logic [15:0] r_fcrc, n_fcrc;

    logic [15:0] crc_cur;
    logic [15:0] crc_upd;
    logic [15:0] off;
    logic        fwd;
    logic [16:0] total;
    logic [2:0]  status;

    assign crc_cur = (r_pos == POS_SYNC_FIRST) ? i_cfg.crc_seed : r_crc;
    assign crc_upd = crc_byte(crc_cur, i_byte);
    assign off     = r_pos - HDR_LEN;
    assign total   = {1'b0, r_pos} + 17'd1;

    // absorb the byte
    always_comb begin
        n_sync = r_sync;
        n_seq  = r_seq;
        n_ver  = r_ver;
        n_cmd  = r_cmd;
        n_len  = r_len;
        n_crc  = crc_cur;
        n_fcrc = r_fcrc;
        fwd    = 1'b0;
        if (r_pos < HDR_LEN) begin
            unique case (r_pos)
                POS_SYNC_FIRST:  n_sync = r_sync | (i_byte != i_cfg.sync_first);
                POS_SYNC_SECOND: n_sync = r_sync | (i_byte != i_cfg.sync_second);
                POS_SYNC_THIRD:  n_sync = r_sync | (i_byte != i_cfg.sync_third);
                POS_SEQ_LO:      n_seq  = {r_seq[15:8], i_byte};
                POS_SEQ_HI:      n_seq  = {i_byte, r_seq[7:0]};
                POS_VERSION:     n_ver  = i_byte;
                POS_COMMAND:     n_cmd  = i_byte;
                POS_LEN_LO:      n_len  = {r_len[15:8], i_byte};
                default:         n_len  = {i_byte, r_len[7:0]};
            endcase
            if (r_pos >= POS_SEQ_LO) begin
                n_crc = crc_upd;
            end
        end else if (r_pos != POS_MAX) begin
            if (off < r_len) begin
                n_crc = crc_upd;
                fwd   = 1'b1;
            end else if (off == r_len) begin
                n_fcrc = {r_fcrc[15:8], i_byte};
            end else if ({1'b0, off} == ({1'b0, r_len} + 17'd1)) begin
                n_fcrc = {i_byte, r_fcrc[7:0]};
            end
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 16'd1;
    end

    // status, in precedence order, on the state after this byte
    always_comb begin
        if (total > {1'b0, i_cfg.max_buffer_len}) begin
            status = ST_OVERFLOW;
        end else if (total < MIN_FRAME) begin
            status = ST_SHORT;
        end else if (n_sync) begin
            status = ST_BAD_SYNC;
        end else if (n_len > i_cfg.max_payload_len) begin
            status = ST_OVERFLOW;
        end else if (total < (MIN_FRAME + {1'b0, n_len})) begin
            status = ST_SHORT;
        end else if (n_crc != n_fcrc) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result     = '0;
        o_has_result = i_last || fwd;
        if (i_last) begin
            o_result.item_kind        = KIND_STATUS;
            o_result.status_code      = status;
            o_result.sequence_id      = n_seq;
            o_result.protocol_version = n_ver;
            o_result.command_code     = n_cmd;
            o_result.payload_length   = n_len;
            o_result.received_check   = n_fcrc;
            o_result.computed_check   = n_crc;
        end else begin
            o_result.item_kind      = KIND_DATA;
            o_result.payload_data   = fwd ? i_byte : 8'd0;
            o_result.payload_offset = fwd ? off : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_sync <= 1'b0;
            r_seq  <= '0;
            r_ver  <= '0;
            r_cmd  <= '0;
            r_len  <= '0;
            r_crc  <= RST_CRC_SEED;
            r_fcrc <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos  <= '0;
                r_sync <= 1'b0;
                r_seq  <= '0;
                r_ver  <= '0;
                r_cmd  <= '0;
                r_len  <= '0;
                r_crc  <= i_cfg.crc_seed;
                r_fcrc <= '0;
            end else begin
                r_pos  <= n_pos;
                r_sync <= n_sync;
                r_seq  <= n_seq;
                r_ver  <= n_ver;
                r_cmd  <= n_cmd;
                r_len  <= n_len;
                r_crc  <= n_crc;
                r_fcrc <= n_fcrc;
            end
        end
    end

endmodule

[hdl/packet_deframer_crc16_check_unit.sv]
// ----------------------------------------------------------------------------
// packet_deframer_crc16_check_unit
// Streaming frame parser: sync check, header decode, CRC-16/CCITT check,
// payload forwarding and one status per received buffer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          transfer carries
//  i_in      in   valid/ready        rx_byte, end_of_buffer
//  o_out     out  valid/ready        payload byte + offset, or buffer status
//  apb       in   psel/penable/...   config write/read, pready tied high
//
//  One byte per cycle sustained while o_out accepts results. A byte sits
//  in the input register, where the per-buffer state, the bytewise CRC
//  update and the status decision are evaluated; if it yields a result,
//  that result then lands in the output register, which drives o_out.
//  Reset (synchronous, active low) restores register defaults and clears
//  the frame state. A stall on o_out backs up only if the waiting byte
//  produces a result; bytes without a result keep flowing.
// ----------------------------------------------------------------------------
module packet_deframer_crc16_check_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pdcrc_in_if.sink                     i_in,
    pdcrc_out_if.source                  o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdcrc_pkg::APB_AW-1:0] paddr,
    input  logic [pdcrc_pkg::APB_DW-1:0] pwdata,
    output logic [pdcrc_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import pdcrc_pkg::*;

    t_cfg    cfg;

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // output register
    logic    r_out_valid;
    t_result r_out;

    logic    has_result;
    t_result result;
    logic    out_free;
    logic    s1_go;
    logic    in_fire;

    pdcrc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the byte in the input register commits to the frame state on s1_go
    pdcrc_parse u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_step       (s1_go),
        .i_byte       (r_s1_byte),
        .i_last       (r_s1_last),
        .o_has_result (has_result),
        .o_result     (result)
    );

    // output slot is free if empty or being drained this cycle
    assign out_free   = !r_out_valid || o_out.ready;
    // a byte with no result never waits for the output side
    assign s1_go      = r_s1_valid && (out_free || !has_result);
    assign i_in.ready = !r_s1_valid || s1_go;
    assign in_fire    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_in.rx_byte;
            r_s1_last <= i_in.end_of_buffer;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && has_result) begin
            r_out <= result;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.item_kind        = r_out.item_kind;
    assign o_out.payload_data     = r_out.payload_data;
    assign o_out.payload_offset   = r_out.payload_offset;
    assign o_out.status_code      = r_out.status_code;
    assign o_out.sequence_id      = r_out.sequence_id;
    assign o_out.protocol_version = r_out.protocol_version;
    assign o_out.command_code     = r_out.command_code;
    assign o_out.payload_length   = r_out.payload_length;
    assign o_out.received_check   = r_out.received_check;
    assign o_out.computed_check   = r_out.computed_check;

    // a held byte stays put until it commits
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_go) |=> (r_s1_valid && $stable(r_s1_byte) && $stable(r_s1_last)))
        else $error("input register changed while stalled");

    // a waiting result is not dropped
    a_out_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("pending result lost");

    // no commit into an occupied, stalled output slot
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !(s1_go && has_result))
        else $error("output register overwritten");

    // forwarded bytes carry no status, status codes stay in range
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.item_kind == KIND_DATA && r_out.status_code == ST_OK)
                      || (r_out.item_kind == KIND_STATUS && r_out.status_code <= ST_CRC
                          && r_out.payload_data == 8'd0)))
        else $error("inconsistent result fields");

endmodule

[bench/pdcrc_checker.sv]
// ----------------------------------------------------------------------------
// pdcrc_checker
// Watches the byte, result and register ports of the deframer, predicts each
// payload byte and buffer status, and compares every result transfer.
// ----------------------------------------------------------------------------
package pdcrc_tb_pkg;

    // CRC-16/CCITT, MSB first, one bit at a time
    function automatic logic [15:0] ccitt_update(input logic [15:0] crc,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ data[i];
            c  = {c[14:0], 1'b0};
            if (fb) c = c ^ pdcrc_pkg::CRC_POLY;
        end
        return c;
    endfunction

endpackage

module pdcrc_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pdcrc_in_if                          in_ch,
    pdcrc_out_if                         out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdcrc_pkg::APB_AW-1:0] paddr,
    input  logic [pdcrc_pkg::APB_DW-1:0] pwdata,
    input  logic                         pready,
    output int                           o_fail_count,
    output int                           o_outstanding,
    output int                           o_payload_count,
    output int                           o_status_count
);
    import pdcrc_pkg::*;
    import pdcrc_tb_pkg::*;

    t_cfg        cfg;
    logic [15:0] byte_count;
    logic        sync_bad;
    logic [15:0] seq_id;
    logic [7:0]  version;
    logic [7:0]  command;
    logic [15:0] plen;
    logic [15:0] crc_run;
    logic [15:0] crc_rx;

    t_result     due_results[$];
    int          fails;
    int          payload_seen;
    int          status_seen;

    assign o_fail_count    = fails;
    assign o_payload_count = payload_seen;
    assign o_status_count  = status_seen;

    task automatic clear_buffer();
        byte_count = '0;
        sync_bad   = 1'b0;
        seq_id     = '0;
        version    = '0;
        command    = '0;
        plen       = '0;
        crc_run    = cfg.crc_seed;
        crc_rx     = '0;
    endtask

    // one received byte: update the frame state, queue what it should yield
    task automatic deframe_byte(input logic [7:0] b, input logic last);
        logic [15:0] at;
        logic [15:0] off;
        logic [16:0] total;
        logic        fwd;
        t_result     r;
        at  = byte_count;
        off = '0;
        fwd = 1'b0;
        r   = '0;
        if (at == POS_SYNC_FIRST) crc_run = cfg.crc_seed;
        case (at)
            POS_SYNC_FIRST:  if (b != cfg.sync_first)  sync_bad = 1'b1;
            POS_SYNC_SECOND: if (b != cfg.sync_second) sync_bad = 1'b1;
            POS_SYNC_THIRD:  if (b != cfg.sync_third)  sync_bad = 1'b1;
            POS_SEQ_LO:      seq_id[7:0]  = b;
            POS_SEQ_HI:      seq_id[15:8] = b;
            POS_VERSION:     version      = b;
            POS_COMMAND:     command      = b;
            POS_LEN_LO:      plen[7:0]    = b;
            POS_LEN_HI:      plen[15:8]   = b;
            POS_MAX:         ;  // counter saturated, byte dropped
            default: begin
                off = at - HDR_LEN;
                if (off < plen) begin
                    crc_run = ccitt_update(crc_run, b);
                    fwd     = 1'b1;
                end else if (off == plen) begin
                    crc_rx[7:0] = b;
                end else if ({1'b0, off} == {1'b0, plen} + 17'd1) begin
                    crc_rx[15:8] = b;
                end
            end
        endcase
        if (at >= POS_SEQ_LO && at < HDR_LEN) crc_run = ccitt_update(crc_run, b);
        if (at != POS_MAX) byte_count = at + 16'd1;

        if (last) begin
            total = {1'b0, at} + 17'd1;
            if (total > {1'b0, cfg.max_buffer_len})      r.status_code = ST_OVERFLOW;
            else if (total < MIN_FRAME)                  r.status_code = ST_SHORT;
            else if (sync_bad)                           r.status_code = ST_BAD_SYNC;
            else if (plen > cfg.max_payload_len)         r.status_code = ST_OVERFLOW;
            else if (total < MIN_FRAME + {1'b0, plen})   r.status_code = ST_SHORT;
            else if (crc_run != crc_rx)                  r.status_code = ST_CRC;
            else                                         r.status_code = ST_OK;
            r.item_kind        = KIND_STATUS;
            r.sequence_id      = seq_id;
            r.protocol_version = version;
            r.command_code     = command;
            r.payload_length   = plen;
            r.received_check   = crc_rx;
            r.computed_check   = crc_run;
            due_results.push_back(r);
            clear_buffer();
        end else if (fwd) begin
            r.item_kind      = KIND_DATA;
            r.payload_data   = b;
            r.payload_offset = off;
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    initial begin
        fails        = 0;
        payload_seen = 0;
        status_seen  = 0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_SYNC_THIRD,
                    RST_MAX_PAYLOAD, RST_MAX_BUFFER, RST_CRC_SEED};
            clear_buffer();
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_SYNC_FIRST:  cfg.sync_first      = pwdata[7:0];
                    REG_SYNC_SECOND: cfg.sync_second     = pwdata[7:0];
                    REG_SYNC_THIRD:  cfg.sync_third      = pwdata[7:0];
                    REG_MAX_PAYLOAD: cfg.max_payload_len = pwdata[15:0];
                    REG_MAX_BUFFER:  cfg.max_buffer_len  = pwdata[15:0];
                    REG_CRC_SEED:    cfg.crc_seed        = pwdata[15:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                deframe_byte(in_ch.rx_byte, in_ch.end_of_buffer);
            if (out_ch.valid && out_ch.ready) begin
                if (due_results.size() == 0) begin
                    $error("result transfer with nothing expected (kind %0b)",
                           out_ch.item_kind);
                    fails++;
                end else begin
                    want = due_results.pop_front();
                    check_field("item_kind",        want.item_kind,        out_ch.item_kind);
                    check_field("payload_data",     want.payload_data,     out_ch.payload_data);
                    check_field("payload_offset",   want.payload_offset,   out_ch.payload_offset);
                    check_field("status_code",      want.status_code,      out_ch.status_code);
                    check_field("sequence_id",      want.sequence_id,      out_ch.sequence_id);
                    check_field("protocol_version", want.protocol_version, out_ch.protocol_version);
                    check_field("command_code",     want.command_code,     out_ch.command_code);
                    check_field("payload_length",   want.payload_length,   out_ch.payload_length);
                    check_field("received_check",   want.received_check,   out_ch.received_check);
                    check_field("computed_check",   want.computed_check,   out_ch.computed_check);
                    if (want.item_kind == KIND_STATUS) status_seen++;
                    else payload_seen++;
                end
            end
        end
        o_outstanding <= due_results.size();
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the packet deframer: directed frames, then random
// well-formed, damaged and noise buffers under six register settings and
// three flow-control mixes; the checker does all result comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import pdcrc_pkg::*;
    import pdcrc_tb_pkg::*;

    localparam int QUIET_LIMIT = 3000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES = 400;   // long receiver stall for back-pressure
    localparam int ROUND_ITEMS = 210;   // random bytes per round, six rounds

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pdcrc_in_if  in_ch ();
    pdcrc_out_if out_ch ();

    int fail_count;
    int outstanding;
    int payload_count;
    int status_count;

    // flow-control knobs, percent of cycles spent idle
    int send_idle_pct = 11;
    int recv_idle_pct = 61;
    int hold_requests = 0;

    int bytes_sent    = 0;
    int buffers_sent  = 0;
    int settings_used = 1;

    t_cfg       cur_cfg;        // register values as last written
    logic [7:0] frame_bytes[$]; // buffer being assembled

    packet_deframer_crc16_check_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pdcrc_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_payload_count (payload_count),
        .o_status_count  (status_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Result side: random ready, plus a long hold-off whenever the
    // stimulus bumps hold_requests. The hold is counted here so the
    // sender keeps offering bytes meanwhile and the block backs up.
    // ------------------------------------------------------------------
    initial begin : receiver
        int holds_done;
        int held;
        holds_done = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != holds_done) begin
                holds_done++;
                out_ch.ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transfer or register access resets the quiet count.
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    // APB write: setup cycle, then access cycle; pready is always high
    task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Stop offering bytes and let every queued result come out. Header and
    // CRC bytes yield nothing, so the wait runs on past the last result.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_config(input t_cfg c);
        drain();
        apb_write(REG_SYNC_FIRST,  {24'd0, c.sync_first});
        apb_write(REG_SYNC_SECOND, {24'd0, c.sync_second});
        apb_write(REG_SYNC_THIRD,  {24'd0, c.sync_third});
        apb_write(REG_MAX_PAYLOAD, {16'd0, c.max_payload_len});
        apb_write(REG_MAX_BUFFER,  {16'd0, c.max_buffer_len});
        apb_write(REG_CRC_SEED,    {16'd0, c.crc_seed});
        cur_cfg = c;
        settings_used++;
    endtask

    // One byte transfer. Valid stays high from one byte to the next unless
    // the random idle draw drops it in between.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= b;
        in_ch.end_of_buffer <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // first n bytes of frame_bytes as one buffer, flag on the last one
    task automatic send_buffer(input int n);
        for (int k = 0; k < n; k++) send_byte(frame_bytes[k], k == n - 1);
        buffers_sent++;
    endtask

    // well-formed frame under the current settings, random payload
    task automatic build_frame(input logic [15:0] seq, input logic [7:0] ver,
                               input logic [7:0] cmd, input logic [15:0] len);
        logic [15:0] crc;
        frame_bytes.delete();
        frame_bytes.push_back(cur_cfg.sync_first);
        frame_bytes.push_back(cur_cfg.sync_second);
        frame_bytes.push_back(cur_cfg.sync_third);
        frame_bytes.push_back(seq[7:0]);
        frame_bytes.push_back(seq[15:8]);
        frame_bytes.push_back(ver);
        frame_bytes.push_back(cmd);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(len[15:8]);
        for (int k = 0; k < len; k++) frame_bytes.push_back(8'($urandom));
        crc = cur_cfg.crc_seed;
        for (int k = 3; k < frame_bytes.size(); k++) crc = ccitt_update(crc, frame_bytes[k]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
    endtask

    // mostly short payloads, now and then up to a few hundred bytes
    function automatic logic [15:0] pick_len();
        int cap;
        cap = (cur_cfg.max_payload_len < 24) ? cur_cfg.max_payload_len : 24;
        if ($urandom_range(99) < 5)
            cap = (cur_cfg.max_payload_len < 300) ? cur_cfg.max_payload_len : 300;
        return 16'($urandom_range(cap));
    endfunction

    function automatic t_cfg round_setting(input int r);
        t_cfg c;
        case (r)
            1:       c = '{8'h00, 8'hFF, 8'h00, 16'd0, 16'd11, 16'h0000};
            3:       c = '{8'hFF, 8'h00, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            5:       c = '{8'($urandom), 8'($urandom), 8'($urandom),
                           16'hFFFF, 16'hFFFF, 16'h1D0F};
            default: c = '{8'($urandom), 8'($urandom), 8'($urandom),
                           16'($urandom_range(64, 8)), 16'($urandom_range(120, 20)),
                           16'($urandom)};
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // One random buffer. About half are clean frames (some with junk
    // after the CRC); the rest are CRC hits, sync hits, early ends,
    // oversized length fields and plain noise.
    // ------------------------------------------------------------------
    task automatic random_buffer();
        int          pick;
        int          n;
        int          at;
        logic [15:0] big;
        pick = $urandom_range(99);
        build_frame(16'($urandom), 8'($urandom), 8'($urandom), pick_len());
        n = frame_bytes.size();
        if (pick < 50) begin
            // trailing bytes after the CRC are ignored by the block
            if ($urandom_range(4) == 0) begin
                n = n + $urandom_range(4, 1);
                while (frame_bytes.size() < n) frame_bytes.push_back(8'($urandom));
            end
        end else if (pick < 62) begin
            // single bit flip anywhere past the sync bytes
            at = $urandom_range(n - 1, 3);
            frame_bytes[at] = frame_bytes[at] ^ 8'(1 << $urandom_range(7));
        end else if (pick < 70) begin
            at = $urandom_range(2);
            frame_bytes[at] = frame_bytes[at] ^ 8'($urandom_range(255, 1));
        end else if (pick < 82) begin
            // buffer ends early: inside the header, payload or CRC
            n = $urandom_range(n - 1, 1);
        end else if (pick < 90 && cur_cfg.max_payload_len != 16'hFFFF) begin
            // length field just over, or far over, the limit
            if ($urandom_range(1) == 0)
                big = cur_cfg.max_payload_len + 16'd1;
            else
                big = cur_cfg.max_payload_len
                    + 16'($urandom_range(16'hFFFF - cur_cfg.max_payload_len, 1));
            frame_bytes[7] = big[7:0];
            frame_bytes[8] = big[15:8];
        end else begin
            n = $urandom_range(40, 1);
            frame_bytes.delete();
            for (int k = 0; k < n; k++) frame_bytes.push_back(8'($urandom));
        end
        send_buffer(n);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int round_end;
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.rx_byte       <= '0;
        in_ch.end_of_buffer <= 1'b0;
        cur_cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_SYNC_THIRD,
                    RST_MAX_PAYLOAD, RST_MAX_BUFFER, RST_CRC_SEED};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rounds 0-1: sender idles 11%, receiver 61%
        // rounds 2-3: the other way round; rounds 4-5: no idling
        for (int r = 0; r < 6; r++) begin
            send_idle_pct = (r < 2) ? 11 : (r < 4) ? 61 : 0;
            recv_idle_pct = (r < 2) ? 61 : (r < 4) ? 11 : 0;
            if (r > 0) set_config(round_setting(r));

            if (r == 0) begin
                // minimum-size good frame with extreme header fields
                build_frame(16'hFFFF, 8'hFF, 8'h00, 16'd0);
                send_buffer(11);
                // one-byte buffer: too short, no field reached
                frame_bytes.delete();
                frame_bytes.push_back(8'h00);
                send_buffer(1);
                // ends on a payload byte: status only, that byte not forwarded
                build_frame(16'h0000, 8'h00, 8'hFF, 16'd5);
                send_buffer(12);
            end

            if (r == 1) begin
                // payload at the length limit fills the buffer limit exactly,
                // then the same with one extra byte to go over it
                build_frame(16'($urandom), 8'($urandom), 8'($urandom),
                            cur_cfg.max_payload_len);
                send_buffer(frame_bytes.size());
                build_frame(16'($urandom), 8'($urandom), 8'($urandom),
                            cur_cfg.max_payload_len);
                frame_bytes.push_back(8'($urandom));
                send_buffer(frame_bytes.size());
            end

            if (r == 4) begin
                // long receiver stall while a long payload keeps coming
                hold_requests <= hold_requests + 1;
                build_frame(16'($urandom), 8'($urandom), 8'($urandom), 16'd200);
                send_buffer(frame_bytes.size());
            end

            round_end = bytes_sent + ROUND_ITEMS;
            while (bytes_sent < round_end) random_buffer();
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d byte transfers in %0d buffers under %0d register settings",
                 bytes_sent, buffers_sent, settings_used);
        $display("Checked %0d forwarded payload bytes and %0d buffer statuses",
                 payload_count, status_count);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
